FILE: sv/pfp_pkg.sv
// Shared constants for the parameter frame parser: parser phases, widths, register map.
`timescale 1ns / 1ps

package pfp_pkg;

   localparam int NUM_PARAMS_DEFAULT     = 4;
   localparam int BYTES_PER_WORD_DEFAULT = 4;

   localparam int BYTE_W  = 8;
   localparam int ID_W    = 2;
   localparam int WORD_W  = 32;
   localparam int PHASE_W = 3;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;
   localparam int REG_SEL_W = 2;

   localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ID    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_DATA  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_TAIL0 = 3'd3;
   localparam logic [PHASE_W-1:0] PH_TAIL1 = 3'd4;

   localparam logic [REG_SEL_W-1:0] REG_HEADER = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_TAIL0  = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_TAIL1  = 2'd2;

endpackage

FILE: sv/param_frame_parser_core.sv
// Top level of the parameter frame parser: byte parser, parameter word memory, CSRs.
`timescale 1ns / 1ps

// Serial command frame parser.
// req_* carries one received byte per word: header, parameter id, data bytes
// (least significant first), then two tail bytes. The header and tail values
// come from three CSRs at byte addresses 0, 4 and 8 of the APB-style port.
// Data bytes land in a parameter word memory (one entry per id, registered
// read) as they arrive. When both tail bytes match, one word
// leaves on rsp_*: the id and the full stored word of that parameter.
// Throughput: one byte per cycle when not stalled. The word read is issued when
// the first tail byte matches, so it is ready by the second tail byte; a result
// appears on rsp_* the cycle after that byte is taken. The output register parts
// the two sides; req_stall is raised only while a result waits and rsp_stall is high.
// Reset (synchronous) returns the parser to the header hunt, clears the CSRs,
// and clears the per-entry valid bits, so every parameter word reads as zero
// until a frame writes it. No clearing pass is needed.
module param_frame_parser_core #(
   parameter int NUM_PARAMS     = pfp_pkg::NUM_PARAMS_DEFAULT,
   parameter int BYTES_PER_WORD = pfp_pkg::BYTES_PER_WORD_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pfp_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pfp_pkg::ID_W-1:0]     rsp_param_id,
   output logic [pfp_pkg::WORD_W-1:0]   rsp_param_word,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pfp_pkg::ADDR_W-1:0]   paddr,
   input  logic [pfp_pkg::DATA_W-1:0]   pwdata,
   output logic [pfp_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);

   localparam int IW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam int CW = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;
   localparam int MW = pfp_pkg::BYTE_W * BYTES_PER_WORD;

   // CSRs
   logic [pfp_pkg::BYTE_W-1:0] header_ff, tail0_ff, tail1_ff;
   logic                       csr_wr;
   logic [pfp_pkg::REG_SEL_W-1:0] csr_sel;

   assign pready  = 1'b1;
   assign csr_sel = paddr[pfp_pkg::REG_SEL_W+1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
         tail0_ff  <= '0;
         tail1_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_sel)
            pfp_pkg::REG_HEADER: header_ff <= pwdata[pfp_pkg::BYTE_W-1:0];
            pfp_pkg::REG_TAIL0:  tail0_ff  <= pwdata[pfp_pkg::BYTE_W-1:0];
            pfp_pkg::REG_TAIL1:  tail1_ff  <= pwdata[pfp_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         pfp_pkg::REG_HEADER: prdata = pfp_pkg::DATA_W'(header_ff);
         pfp_pkg::REG_TAIL0:  prdata = pfp_pkg::DATA_W'(tail0_ff);
         pfp_pkg::REG_TAIL1:  prdata = pfp_pkg::DATA_W'(tail1_ff);
         default:             prdata = '0;
      endcase
   end

   // Parser control
   logic [pfp_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [IW-1:0]               frame_id_ff, frame_id_in;
   logic                        in_acc, out_acc;
   logic                        mem_wr, mem_rd, emit;
   logic [pfp_pkg::BYTE_W-1:0]  b;
   logic                        rsp_valid_ff, rsp_valid_in;

   assign b         = req_rx_byte;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign in_acc    = req_valid && !req_stall;
   assign out_acc   = rsp_valid_ff && !rsp_stall;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      frame_id_in = frame_id_ff;
      mem_wr      = 1'b0;
      mem_rd      = 1'b0;
      emit        = 1'b0;
      if (in_acc) begin
         case (phase_ff)
            pfp_pkg::PH_HUNT: begin
               if (b == header_ff) phase_in = pfp_pkg::PH_ID;
            end
            pfp_pkg::PH_ID: begin
               if (b < pfp_pkg::BYTE_W'(NUM_PARAMS)) begin
                  frame_id_in = IW'(b);
                  count_in    = '0;
                  phase_in    = pfp_pkg::PH_DATA;
               end else begin
                  phase_in = pfp_pkg::PH_HUNT;
               end
            end
            pfp_pkg::PH_DATA: begin
               mem_wr = 1'b1;
               if (count_ff == CW'(BYTES_PER_WORD - 1)) begin
                  phase_in = pfp_pkg::PH_TAIL0;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            pfp_pkg::PH_TAIL0: begin
               if (b == tail0_ff) begin
                  mem_rd   = 1'b1;
                  phase_in = pfp_pkg::PH_TAIL1;
               end else begin
                  phase_in = pfp_pkg::PH_HUNT;
               end
            end
            pfp_pkg::PH_TAIL1: begin
               emit     = (b == tail1_ff);
               phase_in = pfp_pkg::PH_HUNT;
            end
            default: phase_in = pfp_pkg::PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= pfp_pkg::PH_HUNT;
         count_ff    <= '0;
         frame_id_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         frame_id_ff <= frame_id_in;
      end
   end

   // Parameter word memory; an entry not yet written reads as zero
   logic [MW-1:0]         mem [NUM_PARAMS];
   logic [NUM_PARAMS-1:0] entry_valid_ff;
   logic [MW-1:0]         rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         for (int l = 0; l < BYTES_PER_WORD; l++) begin
            // first write to an entry zeroes the other lanes
            if (count_ff == CW'(l)) begin
               mem[frame_id_ff][l*pfp_pkg::BYTE_W +: pfp_pkg::BYTE_W] <= b;
            end else if (!entry_valid_ff[frame_id_ff]) begin
               mem[frame_id_ff][l*pfp_pkg::BYTE_W +: pfp_pkg::BYTE_W] <= '0;
            end
         end
      end
      if (mem_rd) begin
         rd_data_ff  <= mem[frame_id_ff];
         rd_valid_ff <= entry_valid_ff[frame_id_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (mem_wr) begin
         entry_valid_ff[frame_id_ff] <= 1'b1;
      end
   end

   // Output register
   logic [pfp_pkg::ID_W-1:0]     rsp_id_ff;
   logic [pfp_pkg::WORD_W-1:0]   rsp_word_ff;
   logic [63:0]                  rd_word_ext;

   assign rd_word_ext  = rd_valid_ff ? 64'(rd_data_ff) : 64'd0;
   assign rsp_valid_in = emit || (rsp_valid_ff && !out_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_id_ff   <= pfp_pkg::ID_W'(frame_id_ff);
         rsp_word_ff <= rd_word_ext[pfp_pkg::WORD_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_param_id   = rsp_id_ff;
   assign rsp_param_word = rsp_word_ff;

   // Checks
   a_rsp_from_tail : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_acc && phase_ff == pfp_pkg::PH_TAIL1))
      else $error("result raised without a second tail byte");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty output register");

   a_id_in_range : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pfp_pkg::PH_DATA || phase_ff == pfp_pkg::PH_TAIL1)
         |-> (32'(frame_id_ff) < NUM_PARAMS))
      else $error("frame id out of range during frame");

   a_last_data : assert property (@(posedge clock) disable iff (reset)
      (in_acc && phase_ff == pfp_pkg::PH_DATA && count_ff == CW'(BYTES_PER_WORD - 1))
         |=> (phase_ff == pfp_pkg::PH_TAIL0))
      else $error("last data byte did not advance to tail");

endmodule

FILE: test/pfp_frame_checker.sv
// Frame parser checker: tracks CSR writes, predicts completed frames, compares results.
`timescale 1ns / 1ps

module pfp_frame_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [pfp_pkg::BYTE_W-1:0]   req_rx_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [pfp_pkg::ID_W-1:0]     rsp_param_id,
   input  logic [pfp_pkg::WORD_W-1:0]   rsp_param_word,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic                         pready,
   input  logic [pfp_pkg::ADDR_W-1:0]   paddr,
   input  logic [pfp_pkg::DATA_W-1:0]   pwdata,
   output int                           fail_count,
   output int                           pending
);

   localparam int PARAM_CNT  = pfp_pkg::NUM_PARAMS_DEFAULT;
   localparam int WORD_BYTES = pfp_pkg::BYTES_PER_WORD_DEFAULT;

   typedef struct packed {
      logic [pfp_pkg::ID_W-1:0]   id;
      logic [pfp_pkg::WORD_W-1:0] word;
   } frame_result_type;

   logic [pfp_pkg::BYTE_W-1:0]  hdr_byte;
   logic [pfp_pkg::BYTE_W-1:0]  tail_a;
   logic [pfp_pkg::BYTE_W-1:0]  tail_b;
   logic [pfp_pkg::PHASE_W-1:0] phase;
   int unsigned                 byte_idx;
   logic [pfp_pkg::ID_W-1:0]    cur_id;
   logic [pfp_pkg::WORD_W-1:0]  param_store [PARAM_CNT];
   frame_result_type            expected_frames [$];
   int                          errors = 0;

   // Advance the parser by one received byte; queue a result on a good tail.
   function automatic void parse_byte(input logic [pfp_pkg::BYTE_W-1:0] b);
      case (phase)
         pfp_pkg::PH_HUNT: begin
            if (b == hdr_byte) phase = pfp_pkg::PH_ID;
         end
         pfp_pkg::PH_ID: begin
            if (b < PARAM_CNT) begin
               cur_id   = b[pfp_pkg::ID_W-1:0];
               byte_idx = 0;
               phase    = pfp_pkg::PH_DATA;
            end else begin
               phase = pfp_pkg::PH_HUNT;
            end
         end
         pfp_pkg::PH_DATA: begin
            // data lands in the stored word right away, tail or not
            param_store[cur_id][8*byte_idx +: 8] = b;
            byte_idx++;
            if (byte_idx >= WORD_BYTES) phase = pfp_pkg::PH_TAIL0;
         end
         pfp_pkg::PH_TAIL0: begin
            phase = (b == tail_a) ? pfp_pkg::PH_TAIL1 : pfp_pkg::PH_HUNT;
         end
         pfp_pkg::PH_TAIL1: begin
            if (b == tail_b) expected_frames.push_back('{id: cur_id, word: param_store[cur_id]});
            phase = pfp_pkg::PH_HUNT;
         end
         default: begin
            phase = pfp_pkg::PH_HUNT;
         end
      endcase
   endfunction

   always @(posedge clock) begin : track
      frame_result_type want;
      if (reset) begin
         hdr_byte = '0;
         tail_a   = '0;
         tail_b   = '0;
         phase    = pfp_pkg::PH_HUNT;
         byte_idx = 0;
         cur_id   = '0;
         for (int k = 0; k < PARAM_CNT; k++) param_store[k] = '0;
         expected_frames.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[pfp_pkg::ADDR_W-1:2])
               pfp_pkg::REG_HEADER: hdr_byte = pwdata[pfp_pkg::BYTE_W-1:0];
               pfp_pkg::REG_TAIL0:  tail_a   = pwdata[pfp_pkg::BYTE_W-1:0];
               pfp_pkg::REG_TAIL1:  tail_b   = pwdata[pfp_pkg::BYTE_W-1:0];
               default:    ;
            endcase
         end
         // compare before taking the new byte: a result never leaves in the same cycle
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, actual id %0d word %h",
                        $time, rsp_param_id, rsp_param_word);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_param_id !== want.id) begin
                  errors++;
                  $display("%0t: param_id mismatch: expected %0d, actual %0d",
                           $time, want.id, rsp_param_id);
               end
               if (rsp_param_word !== want.word) begin
                  errors++;
                  $display("%0t: param_word mismatch: expected %h, actual %h",
                           $time, want.word, rsp_param_word);
               end
            end
         end
         if (req_valid && !req_stall) parse_byte(req_rx_byte);
      end
      fail_count <= errors;
      pending    <= expected_frames.size();
   end

endmodule

FILE: test/param_frame_parser_core_test.sv
// Testbench top for the parameter frame parser: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module param_frame_parser_core_test;

   localparam int PARAM_CNT     = pfp_pkg::NUM_PARAMS_DEFAULT;
   localparam int PHASE_ITEMS   = 150;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [pfp_pkg::REG_SEL_W-1:0] REG_SPARE = 2'd3;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [pfp_pkg::BYTE_W-1:0]         req_rx_byte = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [pfp_pkg::ID_W-1:0]           rsp_param_id;
   logic [pfp_pkg::WORD_W-1:0]         rsp_param_word;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [pfp_pkg::ADDR_W-1:0]         paddr = '0;
   logic [pfp_pkg::DATA_W-1:0]         pwdata = '0;
   logic [pfp_pkg::DATA_W-1:0]         prdata;
   logic                               pready;

   int fail_count;
   int pending;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   // current framing bytes, used to build frames
   logic [pfp_pkg::BYTE_W-1:0] hdr_byte;
   logic [pfp_pkg::BYTE_W-1:0] tail_a;
   logic [pfp_pkg::BYTE_W-1:0] tail_b;

   always #1 clock = ~clock;

   param_frame_parser_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_param_id   (rsp_param_id),
      .rsp_param_word (rsp_param_word),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   pfp_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_param_id   (rsp_param_id),
      .rsp_param_word (rsp_param_word),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // End the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [pfp_pkg::BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold until every queued result has left, then let the pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [pfp_pkg::REG_SEL_W-1:0] sel,
                            input logic [pfp_pkg::BYTE_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= {{(pfp_pkg::DATA_W-pfp_pkg::BYTE_W){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (sel)
         pfp_pkg::REG_HEADER: hdr_byte = value;
         pfp_pkg::REG_TAIL0:  tail_a   = value;
         pfp_pkg::REG_TAIL1:  tail_b   = value;
         default:    ;
      endcase
   endtask

   task automatic program_framing(input logic [pfp_pkg::BYTE_W-1:0] h,
                                  input logic [pfp_pkg::BYTE_W-1:0] ta,
                                  input logic [pfp_pkg::BYTE_W-1:0] tb);
      csr_write(pfp_pkg::REG_HEADER, h);
      csr_write(pfp_pkg::REG_TAIL0, ta);
      csr_write(pfp_pkg::REG_TAIL1, tb);
   endtask

   // Header, id and the data bytes, least significant first.
   task automatic send_body(input logic [pfp_pkg::BYTE_W-1:0] id,
                            input logic [pfp_pkg::WORD_W-1:0] data);
      send_byte(hdr_byte);
      send_byte(id);
      for (int k = 0; k < pfp_pkg::BYTES_PER_WORD_DEFAULT; k++) send_byte(data[8*k +: 8]);
   endtask

   function automatic logic [pfp_pkg::BYTE_W-1:0] other_than(
      input logic [pfp_pkg::BYTE_W-1:0] good);
      logic [pfp_pkg::BYTE_W-1:0] b;
      b = pfp_pkg::BYTE_W'($urandom_range(255));
      if (b == good) b = b ^ 8'h01;
      // sometimes offer the header value, to check that the miss is not taken as a new frame
      if ($urandom_range(3) == 0 && hdr_byte != good) b = hdr_byte;
      return b;
   endfunction

   task automatic run_random(input int target, input bit mid_pause);
      int sent;
      int pick;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_body(pfp_pkg::BYTE_W'($urandom_range(PARAM_CNT-1)), $urandom());
            send_byte(tail_a);
            send_byte(tail_b);
            sent += 8;
         end else if (pick < 78) begin
            send_byte(pfp_pkg::BYTE_W'($urandom_range(255)));
            sent += 1;
         end else if (pick < 85) begin
            send_byte(hdr_byte);
            send_byte(pfp_pkg::BYTE_W'($urandom_range(255, PARAM_CNT)));
            sent += 2;
         end else if (pick < 93) begin
            send_body(pfp_pkg::BYTE_W'($urandom_range(PARAM_CNT-1)), $urandom());
            send_byte(other_than(tail_a));
            sent += 7;
         end else begin
            send_body(pfp_pkg::BYTE_W'($urandom_range(PARAM_CNT-1)), $urandom());
            send_byte(tail_a);
            send_byte(other_than(tail_b));
            sent += 8;
         end
         if (mid_pause && !paused && sent >= target / 2) begin
            paused = 1'b1;
            settle();
         end
      end
   endtask

   initial begin
      hdr_byte = '0;
      tail_a   = '0;
      tail_b   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_framing(8'hA5, 8'h5A, 8'hC3);
      csr_write(REG_SPARE, 8'hFF);

      // directed: ignored byte, good frame at the top id with all ones,
      // id out of range, bad first tail, bad second tail with all-zero data
      send_byte(8'h00);
      send_body(pfp_pkg::BYTE_W'(PARAM_CNT - 1), 32'hFFFF_FFFF);
      send_byte(tail_a);
      send_byte(tail_b);
      send_byte(hdr_byte);
      send_byte(8'hFF);
      send_body(8'd1, 32'h1234_5678);
      send_byte(hdr_byte);
      send_body(8'd2, 32'h0000_0000);
      send_byte(tail_a);
      send_byte(8'h00);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(PHASE_ITEMS, 1'b1);
      settle();

      program_framing(8'h00, 8'h00, 8'h00);
      send_idle_pct  = 75;
      recv_stall_pct = 0;
      run_random(PHASE_ITEMS, 1'b0);
      settle();

      program_framing(8'hFF, 8'hFF, 8'hFF);
      send_idle_pct  = 0;
      recv_stall_pct = 75;
      run_random(PHASE_ITEMS, 1'b0);
      settle();

      program_framing(pfp_pkg::BYTE_W'($urandom_range(255)),
                      pfp_pkg::BYTE_W'($urandom_range(255)),
                      pfp_pkg::BYTE_W'($urandom_range(255)));
      send_idle_pct  = 38;
      recv_stall_pct = 38;
      run_random(PHASE_ITEMS, 1'b0);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
